// ===== hw/rtl/tkst_pkg.sv =====
// Shared types and constants for the top-k score table.
// No dependencies; used by the interfaces, the slot table and the top level.
package tkst_pkg;

   localparam int ENTRIES  = 10;
   localparam int CNT_W    = $clog2(ENTRIES + 1);
   localparam int FUNC_W   = 2;
   localparam int SCORE_W  = 32;
   localparam int TAG_W    = 32;
   localparam int INDEX_W  = 4;
   localparam int POS_W    = 4;
   localparam int COUNT_W  = 4;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_READ   = 2'd1,
      FUNC_CLEAR  = 2'd2
   } func_type;

   // One request as it sits in the input register.
   typedef struct packed {
      func_type                   func;
      logic signed [SCORE_W-1:0]  score;
      logic [TAG_W-1:0]           tag;
      logic [INDEX_W-1:0]         index;
   } op_type;

   // One response as produced by the slot table.
   typedef struct packed {
      logic                       accepted;
      logic [POS_W-1:0]           position;
      logic [COUNT_W-1:0]         count;
      logic                       entry_valid;
      logic signed [SCORE_W-1:0]  entry_score;
      logic [TAG_W-1:0]           entry_tag;
   } result_type;

endpackage

// ===== hw/rtl/tkst_if.sv =====
// Valid/ready channel interfaces for requests and responses of the score table.
// Depends on tkst_pkg for field widths.
interface tkst_req_if;
   logic                                valid;
   logic                                ready;
   logic [tkst_pkg::FUNC_W-1:0]         func;
   logic signed [tkst_pkg::SCORE_W-1:0] score;
   logic [tkst_pkg::TAG_W-1:0]          player_tag;
   logic [tkst_pkg::INDEX_W-1:0]        index;

   modport source (output valid, func, score, player_tag, index, input ready);
   modport sink   (input valid, func, score, player_tag, index, output ready);
endinterface

interface tkst_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                accepted;
   logic [tkst_pkg::POS_W-1:0]          position;
   logic [tkst_pkg::COUNT_W-1:0]        count;
   logic                                entry_valid;
   logic signed [tkst_pkg::SCORE_W-1:0] entry_score;
   logic [tkst_pkg::TAG_W-1:0]          entry_tag;

   modport source (output valid, accepted, position, count, entry_valid, entry_score,
                   entry_tag, input ready);
   modport sink   (input valid, accepted, position, count, entry_valid, entry_score,
                   entry_tag, output ready);
endinterface

// ===== hw/rtl/top_k_score_table.sv =====
// Top level of the top-k score table: request register, slot table, response register.
// Depends on tkst_pkg, tkst_req_if/tkst_rsp_if and tkst_table.
//
// Keeps the best ENTRIES (score, tag) pairs sorted by descending signed score and
// answers every request (insert, read by index, clear) with exactly one response.
// A request is taken into an input register, the slot table compares all slots in
// parallel and shifts in one pass, and the response lands in an output register.
// One request per cycle is sustained while rsp ready holds, set by the single
// compare-and-shift pass over the slots. A response waiting for rsp ready still
// lets one more request into the input register; once both registers are full,
// req ready stays low until the response is taken.
// There is no clearing pass after reset; the entry count starts at zero.
module top_k_score_table (
   input  logic        clock,
   input  logic        reset,
   tkst_req_if.sink    req_chan,
   tkst_rsp_if.source  rsp_chan
);

   logic                 in_valid_ff;
   logic                 in_valid_in;
   tkst_pkg::op_type     in_op_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   tkst_pkg::result_type rsp_ff;
   tkst_pkg::result_type table_result;
   logic                 advance;
   logic                 take;

   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;
   assign in_valid_in    = take || (in_valid_ff && !advance);
   assign rsp_valid_in   = advance || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_op_ff.func  <= tkst_pkg::func_type'(req_chan.func);
         in_op_ff.score <= req_chan.score;
         in_op_ff.tag   <= req_chan.player_tag;
         in_op_ff.index <= req_chan.index;
      end
      if (advance) begin
         rsp_ff <= table_result;
      end
   end

   tkst_table u_table (
      .clock    (clock),
      .reset    (reset),
      .op_valid (advance),
      .op       (in_op_ff),
      .result   (table_result)
   );

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.accepted    = rsp_ff.accepted;
   assign rsp_chan.position    = rsp_ff.position;
   assign rsp_chan.count       = rsp_ff.count;
   assign rsp_chan.entry_valid = rsp_ff.entry_valid;
   assign rsp_chan.entry_score = rsp_ff.entry_score;
   assign rsp_chan.entry_tag   = rsp_ff.entry_tag;

   // A request that moves into the table always produces a visible response.
   a_advance_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("request left the input register without a response");

   // A stalled request is kept in the input register.
   a_stall_keeps_req: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("stalled request was dropped");

   // A response never reports both an accepted insert and a read hit.
   a_rsp_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.accepted && rsp_ff.entry_valid))
      else $error("response mixes insert and read results");

   // A pending response is never overwritten while the sink holds off.
   a_rsp_not_overwritten: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !advance)
      else $error("pending response overwritten");

endmodule

// ===== hw/rtl/tkst_table.sv =====
// Sorted slot table: parallel compare, insert with shift, indexed read, clear.
// Depends on tkst_pkg. The response is combinational from the op and the slots.
module tkst_table (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 op_valid,
   input  tkst_pkg::op_type     op,
   output tkst_pkg::result_type result
);

   logic signed [tkst_pkg::SCORE_W-1:0] score_ff [tkst_pkg::ENTRIES];
   logic [tkst_pkg::TAG_W-1:0]          tag_ff   [tkst_pkg::ENTRIES];
   logic [tkst_pkg::CNT_W-1:0]          count_ff;
   logic [tkst_pkg::CNT_W-1:0]          count_in;

   logic [tkst_pkg::ENTRIES-1:0]        keep_above;
   logic [tkst_pkg::CNT_W-1:0]          pos;
   logic                                full;
   logic                                ins_ok;
   logic                                do_insert;
   logic                                rd_hit;
   logic signed [tkst_pkg::SCORE_W-1:0] rd_score;
   logic [tkst_pkg::TAG_W-1:0]          rd_tag;

   // The slots are sorted, so the valid entries that stay above the new score
   // form a prefix; their number is the insert position.
   always_comb begin
      pos = '0;
      for (int i = 0; i < tkst_pkg::ENTRIES; i++) begin
         keep_above[i] = (i < int'(count_ff)) && !(op.score > score_ff[i]);
         pos = pos + tkst_pkg::CNT_W'(keep_above[i]);
      end
   end

   assign full      = (count_ff == tkst_pkg::CNT_W'(tkst_pkg::ENTRIES));
   assign ins_ok    = !full || (op.score > score_ff[tkst_pkg::ENTRIES-1]);
   assign do_insert = op_valid && (op.func == tkst_pkg::FUNC_INSERT) && ins_ok;

   always_comb begin
      rd_score = '0;
      rd_tag   = '0;
      for (int i = 0; i < tkst_pkg::ENTRIES; i++) begin
         if (int'(op.index) == i) begin
            rd_score = score_ff[i];
            rd_tag   = tag_ff[i];
         end
      end
   end

   assign rd_hit = (int'(op.index) < int'(count_ff)) && (int'(op.index) < tkst_pkg::ENTRIES);

   always_comb begin
      count_in = count_ff;
      result   = '0;
      case (op.func)
         tkst_pkg::FUNC_INSERT: begin
            if (ins_ok) begin
               if (!full) begin
                  count_in = count_ff + tkst_pkg::CNT_W'(1);
               end
               result.accepted = 1'b1;
               result.position = tkst_pkg::POS_W'(pos);
            end
         end
         tkst_pkg::FUNC_READ: begin
            if (rd_hit) begin
               result.entry_valid = 1'b1;
               result.entry_score = rd_score;
               result.entry_tag   = rd_tag;
            end
         end
         tkst_pkg::FUNC_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
      result.count = tkst_pkg::COUNT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (op_valid) begin
         count_ff <= count_in;
      end
   end

   // Entries below the insert point move down one slot; the last one falls off.
   always_ff @(posedge clock) begin
      if (do_insert) begin
         for (int i = 1; i < tkst_pkg::ENTRIES; i++) begin
            if (tkst_pkg::CNT_W'(i) > pos) begin
               score_ff[i] <= score_ff[i-1];
               tag_ff[i]   <= tag_ff[i-1];
            end
         end
         for (int i = 0; i < tkst_pkg::ENTRIES; i++) begin
            if (tkst_pkg::CNT_W'(i) == pos) begin
               score_ff[i] <= op.score;
               tag_ff[i]   <= op.tag;
            end
         end
      end
   end

endmodule
